@@ rtl/dtr_pkg.sv @@
// Shared types and constants of the divider timer with reload.
package dtr_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [15:0] ADDR_DIVIDER = 16'hFF04;
  localparam logic [15:0] ADDR_COUNTER = 16'hFF05;
  localparam logic [15:0] ADDR_MODULO  = 16'hFF06;
  localparam logic [15:0] ADDR_CONTROL = 16'hFF07;

  localparam int unsigned CTRL_ENABLE_BIT = 2;
  localparam int unsigned CTRL_WIDTH      = 3;

  // controller to datapath
  typedef struct packed {
    logic add;       // add elapsed cycles to divider and prescaler
    logic step;      // drain one prescaler period, advance counter
    logic wr;        // register write from the input transaction
    logic load_bus;  // load result register from a read/write/other transaction
    logic load_tick; // load result register with the tick result
  } dtr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic step_ok;   // timer enabled and prescaler holds a full period
  } dtr_status_t;

  function automatic logic [15:0] step_period(input logic [1:0] sel);
    logic [15:0] p;
    case (sel)
      2'd0:    p = 16'd1024;
      2'd1:    p = 16'd16;
      2'd2:    p = 16'd64;
      2'd3:    p = 16'd256;
      default: p = 16'd1024;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/dtr_if.sv @@
// Valid/ready channel interfaces for the timer input and result transactions.
interface dtr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [7:0]  elapsed;

  modport source (output valid, output command, output address, output write_data,
                  output elapsed, input ready);
  modport sink   (input valid, input command, input address, input write_data,
                  input elapsed, output ready);
endinterface

interface dtr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq;

  modport source (output valid, output read_data, output irq, input ready);
  modport sink   (input valid, input read_data, input irq, output ready);
endinterface

@@ rtl/dtr_datapath.sv @@
// Timer datapath: divider, prescaler, counter, modulo, control and result register.
module dtr_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  dtr_pkg::dtr_cmd_t   cmd,
  output dtr_pkg::dtr_status_t status,
  input  logic [1:0]          in_command,
  input  logic [15:0]         in_address,
  input  logic [7:0]          in_write_data,
  input  logic [7:0]          in_elapsed,
  output logic [7:0]          out_read_data,
  output logic                out_irq
);

  logic [15:0] divider_r,   divider_nxt;
  logic [15:0] prescaler_r, prescaler_nxt;
  logic [7:0]  counter_r,   counter_nxt;
  logic [7:0]  modulo_r,    modulo_nxt;
  logic [dtr_pkg::CTRL_WIDTH-1:0] control_r, control_nxt;
  logic        irq_acc_r,   irq_acc_nxt;
  logic [7:0]  rd_data_r,   rd_data_nxt;
  logic        rd_irq_r,    rd_irq_nxt;
  logic [15:0] period;
  logic [7:0]  bus_rd;

  assign period         = dtr_pkg::step_period(control_r[1:0]);
  assign status.step_ok = control_r[dtr_pkg::CTRL_ENABLE_BIT] && (prescaler_r >= period);

  always_comb begin
    bus_rd = 8'd0;
    if (in_command == dtr_pkg::CMD_READ) begin
      case (in_address)
        dtr_pkg::ADDR_DIVIDER: bus_rd = divider_r[15:8];
        dtr_pkg::ADDR_COUNTER: bus_rd = counter_r;
        dtr_pkg::ADDR_MODULO:  bus_rd = modulo_r;
        dtr_pkg::ADDR_CONTROL: bus_rd = {{(8-dtr_pkg::CTRL_WIDTH){1'b0}}, control_r};
        default:               bus_rd = 8'd0;
      endcase
    end
  end

  always_comb begin
    divider_nxt   = divider_r;
    prescaler_nxt = prescaler_r;
    counter_nxt   = counter_r;
    modulo_nxt    = modulo_r;
    control_nxt   = control_r;
    irq_acc_nxt   = irq_acc_r;
    rd_data_nxt   = rd_data_r;
    rd_irq_nxt    = rd_irq_r;

    if (cmd.add) begin
      divider_nxt   = divider_r + {8'd0, in_elapsed};
      prescaler_nxt = prescaler_r + {8'd0, in_elapsed};
      irq_acc_nxt   = 1'b0;
    end

    if (cmd.step) begin
      prescaler_nxt = prescaler_r - period;
      if (counter_r == 8'hFF) begin
        counter_nxt = modulo_r;
        irq_acc_nxt = 1'b1;
      end else begin
        counter_nxt = counter_r + 8'd1;
      end
    end

    if (cmd.wr) begin
      case (in_address)
        dtr_pkg::ADDR_DIVIDER: begin
          divider_nxt   = 16'd0;
          prescaler_nxt = 16'd0;
        end
        dtr_pkg::ADDR_COUNTER: counter_nxt = in_write_data;
        dtr_pkg::ADDR_MODULO:  modulo_nxt  = in_write_data;
        dtr_pkg::ADDR_CONTROL: control_nxt = in_write_data[dtr_pkg::CTRL_WIDTH-1:0];
        default: ;
      endcase
    end

    if (cmd.load_bus) begin
      rd_data_nxt = bus_rd;
      rd_irq_nxt  = 1'b0;
    end else if (cmd.load_tick) begin
      rd_data_nxt = 8'd0;
      rd_irq_nxt  = irq_acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divider_r   <= '0;
      prescaler_r <= '0;
      counter_r   <= '0;
      modulo_r    <= '0;
      control_r   <= '0;
      irq_acc_r   <= 1'b0;
    end else begin
      divider_r   <= divider_nxt;
      prescaler_r <= prescaler_nxt;
      counter_r   <= counter_nxt;
      modulo_r    <= modulo_nxt;
      control_r   <= control_nxt;
      irq_acc_r   <= irq_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= rd_data_nxt;
    rd_irq_r  <= rd_irq_nxt;
  end

  assign out_read_data = rd_data_r;
  assign out_irq       = rd_irq_r;

`ifndef SYNTH
  a_step_drains: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> prescaler_r < $past(prescaler_r))
    else $error("prescaler did not shrink after a drain step");

  a_step_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> control_r[dtr_pkg::CTRL_ENABLE_BIT] && !cmd.add && !cmd.wr)
    else $error("drain step while disabled or during a bus transaction");
`endif

endmodule

@@ rtl/dtr_ctrl.sv @@
// Timer controller: handshake, tick drain sequencing and result valid.
module dtr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dtr_pkg::dtr_cmd_t    cmd,
  input  dtr_pkg::dtr_status_t status
);

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == dtr_pkg::CMD_TICK) begin
            cmd.add   = 1'b1;
            state_nxt = S_DRAIN;
          end else begin
            cmd.wr        = (in_command == dtr_pkg::CMD_WRITE);
            cmd.load_bus  = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_DRAIN: begin
        if (status.step_ok) begin
          cmd.step = 1'b1;
        end else begin
          cmd.load_tick = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_bus || cmd.load_tick) |-> (!out_valid_r || out_ready))
    else $error("result register loaded while holding an untaken transaction");

  a_tick_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == dtr_pkg::CMD_TICK) |=> state_r == S_DRAIN && !out_valid_r)
    else $error("tick transaction did not enter drain");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept || state_r == S_DRAIN))
    else $error("result valid without a transaction");
`endif

endmodule

@@ rtl/divider_timer_with_reload_unit.sv @@
// Top level of the divider timer with reload.
//   channel  | dir | handshake          | payload
//   in_ch    | in  | valid/ready        | command, address, write_data, elapsed
//   out_ch   | out | valid/ready        | read_data, irq
// For read, write and unused commands the result is registered at accept.
// A tick adds elapsed at accept, then drains N = prescaler / period steps, one per cycle
// through the single counter stepping unit (N <= 16 while the timer stays enabled
// at one period, more after a period change, up to 4095 on the first tick after
// enabling with a large prescaler), and then loads the tick result.
// Synchronous active-low reset clears timer registers and result valid, not the result register.
// A new transaction is taken while a result waits if that result is taken the same cycle.
module divider_timer_with_reload_unit (
  input  logic clk,
  input  logic rst_n,
  dtr_in_if.sink    in_ch,
  dtr_out_if.source out_ch
);

  dtr_pkg::dtr_cmd_t    cmd;
  dtr_pkg::dtr_status_t status;

  dtr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_command (in_ch.command),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd),
    .status     (status)
  );

  dtr_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_command    (in_ch.command),
    .in_address    (in_ch.address),
    .in_write_data (in_ch.write_data),
    .in_elapsed    (in_ch.elapsed),
    .out_read_data (out_ch.read_data),
    .out_irq       (out_ch.irq)
  );

endmodule
